### hw/rtl/coi_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// coi_pkg
// Shared types and constants of the costmap obstacle inflation core.
// ---------------------------------------------------------------------------
package coi_pkg;

   // Field widths fixed by the transaction formats
   localparam int COST_W   = 16;
   localparam int COORD_W  = 6;
   localparam int ENTRY_W  = 12;
   localparam int COUNT_W  = 13;
   localparam int CFG_W    = 7;
   localparam int CSR_W    = 16;

   // Q8.8 one: obstacle level and the cost given to inflated cells
   localparam logic signed [COST_W-1:0] ONE_Q88 = 16'sd256;

   // Register reset values
   localparam logic [CFG_W-1:0]         GRID_WIDTH_RST  = 7'd64;
   localparam logic [CFG_W-1:0]         GRID_HEIGHT_RST = 7'd64;
   localparam logic [CFG_W-1:0]         RADIUS_SQ_RST   = 7'd0;
   localparam logic signed [COST_W-1:0] MISSING_RST     = -16'sd256;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_RUN   = 2'd1,
      OP_READ  = 2'd2,
      OP_ENTRY = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_HEIGHT = 2'd1,
      CSR_RADIUS_SQ   = 2'd2,
      CSR_MISSING     = 2'd3
   } csr_index_type;

   typedef struct packed {
      op_type                    op;
      logic [COORD_W-1:0]        col;
      logic [COORD_W-1:0]        row;
      logic signed [COST_W-1:0]  cost_in;
      logic [ENTRY_W-1:0]        entry;
   } req_type;

   typedef struct packed {
      logic signed [COST_W-1:0]  cost_out;
      logic                      inflated;
      logic                      traversable;
      logic [COORD_W-1:0]        centre_col;
      logic [COORD_W-1:0]        centre_row;
      logic [COUNT_W-1:0]        centre_count;
      logic                      status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_REACH,
      ST_CELL_RD,
      ST_CELL_CHK,
      ST_NB_RD,
      ST_NB_WR,
      ST_FINISH
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic clr_step;
      logic accept;
      logic rsp_load;
      logic rsp_take;
      logic copy_init;
      logic copy_rd;
      logic copy_wr;
      logic reach_step;
      logic cell_rd;
      logic cell_next;
      logic win_init;
      logic nb_rd;
      logic nb_wr;
      logic nb_adv;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clr_last;
      logic copy_last;
      logic run_empty;
      logic reach_more;
      logic cell_obst;
      logic cell_last;
      logic nb_ok;
      logic win_last;
      logic rsp_valid;
   } dp_sts_type;

endpackage
`default_nettype wire

### hw/rtl/coi_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// coi_ctrl
// Sequencer: reset clear pass, host accesses and the inflation run.
// ---------------------------------------------------------------------------
module coi_ctrl
   import coi_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire op_type     req_op,
   output logic            req_stall,
   input  wire logic       rsp_stall,
   input  wire dp_sts_type sts,
   output dp_cmd_type      cmd
);

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      req_stall    = 1'b1;
      // held result taken by the receiver
      cmd.rsp_take = sts.rsp_valid && !rsp_stall;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            // a pending result must leave this cycle before a new transaction enters
            req_stall = sts.rsp_valid && rsp_stall;
            if (req_valid && !req_stall) begin
               cmd.accept = 1'b1;
               if (req_op == OP_RUN) begin
                  cmd.copy_init = 1'b1;
                  state_in      = ST_COPY_RD;
               end else begin
                  state_in = ST_ACCESS;
               end
            end
         end
         ST_ACCESS: begin
            cmd.rsp_load = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_COPY_RD: begin
            cmd.copy_rd = 1'b1;
            state_in    = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            cmd.copy_wr = 1'b1;
            if (sts.copy_last) begin
               state_in = sts.run_empty ? ST_FINISH : ST_REACH;
            end else begin
               state_in = ST_COPY_RD;
            end
         end
         ST_REACH: begin
            if (sts.reach_more) begin
               cmd.reach_step = 1'b1;
            end else begin
               state_in = ST_CELL_RD;
            end
         end
         ST_CELL_RD: begin
            cmd.cell_rd = 1'b1;
            state_in    = ST_CELL_CHK;
         end
         ST_CELL_CHK: begin
            if (sts.cell_obst) begin
               cmd.win_init = 1'b1;
               state_in     = ST_NB_RD;
            end else begin
               cmd.cell_next = 1'b1;
               state_in      = sts.cell_last ? ST_FINISH : ST_CELL_RD;
            end
         end
         ST_NB_RD: begin
            if (sts.nb_ok) begin
               cmd.nb_rd = 1'b1;
               state_in  = ST_NB_WR;
            end else begin
               cmd.nb_adv = 1'b1;
               if (sts.win_last) begin
                  cmd.cell_next = 1'b1;
                  state_in      = sts.cell_last ? ST_FINISH : ST_CELL_RD;
               end
            end
         end
         ST_NB_WR: begin
            cmd.nb_wr  = 1'b1;
            cmd.nb_adv = 1'b1;
            if (sts.win_last) begin
               cmd.cell_next = 1'b1;
               state_in      = sts.cell_last ? ST_FINISH : ST_CELL_RD;
            end else begin
               state_in = ST_NB_RD;
            end
         end
         ST_FINISH: begin
            cmd.rsp_load = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### hw/rtl/coi_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// coi_dp
// Datapath: grid memories, centre list, scan counters and result register.
// ---------------------------------------------------------------------------
module coi_dp
   import coi_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   parameter int MAX_REACH  = 8
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire csr_index_type csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata,
   input  wire req_type     req_data,
   input  wire dp_cmd_type  cmd,
   output dp_sts_type       sts,
   output rsp_type          rsp_data
);

   localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int TW    = $clog2(CELLS + 1);
   localparam int XW    = $clog2(MAX_WIDTH + 1);
   localparam int YW    = $clog2(MAX_HEIGHT + 1);
   localparam int UW    = $clog2(MAX_REACH + 1);
   localparam int RW    = UW + 1;
   localparam int MW    = (XW > YW) ? XW : YW;
   localparam int SW    = ((MW > RW) ? MW : RW) + 1;
   localparam int PW    = 2 * RW + 2;

   // Memories
   logic [COST_W-1:0] base_mem [CELLS];
   logic [COST_W-1:0] work_mem [CELLS];
   logic              mark_mem [CELLS];
   logic [2*COORD_W-1:0] list_mem [CELLS];

   logic signed [COST_W-1:0] base_q, work_q;
   logic                     mark_q;
   logic [2*COORD_W-1:0]     list_q;

   // Registers
   logic [CFG_W-1:0]         grid_width_ff, grid_height_ff, radius_sq_ff;
   logic signed [COST_W-1:0] missing_ff;
   logic [AW-1:0]            sweep_ff;
   op_type                   op_ff;
   logic                     inside_ff, entry_ok_ff;
   logic [UW-1:0]            reach_ff;
   logic [YW-1:0]            r_ff;
   logic [XW-1:0]            c_ff;
   logic signed [RW-1:0]     dx_ff, dy_ff;
   logic [TW-1:0]            total_ff;
   rsp_type                  rsp_ff;
   logic                     rsp_valid_ff;

   // Derived values
   logic [XW-1:0]            used_w;
   logic [YW-1:0]            used_h;
   logic                     host_inside, host_entry_ok;
   logic [AW-1:0]            host_idx, cell_addr, nb_addr, base_raddr, wm_raddr;
   logic signed [SW-1:0]     nx, ny;
   logic signed [PW-1:0]     dist_sq;
   logic signed [RW-1:0]     reach_s;
   logic                     nb_free, nb_new, list_room;
   logic                     sweep_last;
   logic                     base_we, work_we, mark_we, list_we;
   logic [AW-1:0]            base_waddr, work_waddr, mark_waddr;
   logic [COST_W-1:0]        base_wdata, work_wdata;
   logic                     mark_wdata;
   rsp_type                  rsp_in;

   assign used_w = (32'(grid_width_ff) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(grid_width_ff);
   assign used_h = (32'(grid_height_ff) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(grid_height_ff);

   // Host access decode
   assign host_inside   = (32'(req_data.col) < 32'(used_w)) && (32'(req_data.row) < 32'(used_h));
   assign host_idx      = AW'(32'(req_data.row) * MAX_WIDTH + 32'(req_data.col));
   assign host_entry_ok = (32'(req_data.entry) < 32'(total_ff)) && (32'(req_data.entry) < CELLS);

   // Scan addresses
   assign cell_addr = AW'(32'(r_ff) * MAX_WIDTH + 32'(c_ff));
   assign nx        = SW'(signed'({1'b0, c_ff})) + SW'(dx_ff);
   assign ny        = SW'(signed'({1'b0, r_ff})) + SW'(dy_ff);
   assign nb_addr   = AW'(int'(ny) * MAX_WIDTH + int'(nx));
   assign dist_sq   = PW'(dx_ff) * PW'(dx_ff) + PW'(dy_ff) * PW'(dy_ff);
   assign reach_s   = signed'(RW'(reach_ff));
   assign sweep_last = (sweep_ff == AW'(CELLS - 1));

   // Neighbor test on the base cost read for it
   assign nb_free   = (base_q < ONE_Q88) && (base_q > missing_ff);
   assign nb_new    = nb_free && !mark_q;
   assign list_room = (32'(total_ff) < CELLS);

   // Status
   always_comb begin
      sts.clr_last   = sweep_last;
      sts.copy_last  = sweep_last;
      sts.run_empty  = (used_w == '0) || (used_h == '0) || (radius_sq_ff == '0);
      sts.reach_more = (32'(reach_ff) < MAX_REACH) &&
                       ((int'(reach_ff) + 1) * (int'(reach_ff) + 1) <= int'(radius_sq_ff));
      sts.cell_obst  = (base_q >= ONE_Q88);
      sts.cell_last  = (c_ff == used_w - XW'(1)) && (r_ff == used_h - YW'(1));
      sts.nb_ok      = (nx >= 0) && (int'(nx) < int'(used_w)) &&
                       (ny >= 0) && (int'(ny) < int'(used_h)) &&
                       (int'(dist_sq) <= int'(radius_sq_ff));
      sts.win_last   = (dx_ff == reach_s) && (dy_ff == reach_s);
      sts.rsp_valid  = rsp_valid_ff;
   end

   // Read address selection
   assign base_raddr = cmd.copy_rd ? sweep_ff : (cmd.cell_rd ? cell_addr : nb_addr);
   assign wm_raddr   = cmd.accept ? host_idx : nb_addr;

   // Write port selection
   always_comb begin
      base_we    = cmd.clr_step || (cmd.accept && req_data.op == OP_WRITE && host_inside);
      base_waddr = cmd.clr_step ? sweep_ff : host_idx;
      base_wdata = cmd.clr_step ? '0 : req_data.cost_in;

      work_we    = cmd.clr_step || cmd.copy_wr || (cmd.nb_wr && nb_free);
      work_waddr = (cmd.clr_step || cmd.copy_wr) ? sweep_ff : nb_addr;
      work_wdata = cmd.clr_step ? '0 : (cmd.copy_wr ? base_q : ONE_Q88);

      mark_we    = cmd.clr_step || cmd.copy_wr || (cmd.nb_wr && nb_new);
      mark_waddr = (cmd.clr_step || cmd.copy_wr) ? sweep_ff : nb_addr;
      mark_wdata = cmd.nb_wr;

      list_we    = cmd.nb_wr && nb_new && list_room;
   end

   // Memory ports
   always_ff @(posedge clock) begin
      if (base_we) base_mem[base_waddr] <= base_wdata;
      base_q <= base_mem[base_raddr];
   end

   always_ff @(posedge clock) begin
      if (work_we) work_mem[work_waddr] <= work_wdata;
      work_q <= work_mem[wm_raddr];
   end

   always_ff @(posedge clock) begin
      if (mark_we) mark_mem[mark_waddr] <= mark_wdata;
      mark_q <= mark_mem[wm_raddr];
   end

   always_ff @(posedge clock) begin
      if (list_we) list_mem[AW'(total_ff)] <= {COORD_W'(ny), COORD_W'(nx)};
      list_q <= list_mem[AW'(req_data.entry)];
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RST;
         grid_height_ff <= GRID_HEIGHT_RST;
         radius_sq_ff   <= RADIUS_SQ_RST;
         missing_ff     <= MISSING_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_wdata[CFG_W-1:0];
            CSR_GRID_HEIGHT: grid_height_ff <= csr_wdata[CFG_W-1:0];
            CSR_RADIUS_SQ:   radius_sq_ff   <= csr_wdata[CFG_W-1:0];
            CSR_MISSING:     missing_ff     <= signed'(csr_wdata);
            default:         grid_width_ff  <= grid_width_ff;
         endcase
      end
   end

   // Sweep counter, centre total
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         total_ff <= '0;
      end else begin
         if (cmd.copy_init) begin
            sweep_ff <= '0;
         end else if (cmd.clr_step || cmd.copy_wr) begin
            sweep_ff <= sweep_last ? '0 : sweep_ff + AW'(1);
         end
         if (cmd.copy_init) begin
            total_ff <= '0;
         end else if (list_we) begin
            total_ff <= total_ff + TW'(1);
         end
      end
   end

   // Scan position and window offsets
   always_ff @(posedge clock) begin
      if (cmd.copy_init) begin
         reach_ff <= '0;
         r_ff     <= '0;
         c_ff     <= '0;
      end else begin
         if (cmd.reach_step) reach_ff <= reach_ff + UW'(1);
         if (cmd.cell_next) begin
            if (c_ff == used_w - XW'(1)) begin
               c_ff <= '0;
               r_ff <= r_ff + YW'(1);
            end else begin
               c_ff <= c_ff + XW'(1);
            end
         end
      end
      if (cmd.win_init) begin
         dx_ff <= -reach_s;
         dy_ff <= -reach_s;
      end else if (cmd.nb_adv) begin
         if (dx_ff == reach_s) begin
            dx_ff <= -reach_s;
            dy_ff <= dy_ff + RW'(1);
         end else begin
            dx_ff <= dx_ff + RW'(1);
         end
      end
   end

   // Host transaction context
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff       <= req_data.op;
         inside_ff   <= host_inside;
         entry_ok_ff <= host_entry_ok;
      end
   end

   // Result assembly
   always_comb begin
      rsp_in              = '0;
      rsp_in.centre_count = COUNT_W'(total_ff);
      case (op_ff)
         OP_WRITE: rsp_in.status = !inside_ff;
         OP_RUN:   rsp_in.status = 1'b0;
         OP_READ: begin
            rsp_in.status = !inside_ff;
            if (inside_ff) begin
               rsp_in.cost_out    = work_q;
               rsp_in.inflated    = mark_q;
               rsp_in.traversable = (work_q > missing_ff) && (work_q < ONE_Q88);
            end
         end
         OP_ENTRY: begin
            rsp_in.status = !entry_ok_ff;
            if (entry_ok_ff) begin
               rsp_in.centre_col = list_q[COORD_W-1:0];
               rsp_in.centre_row = list_q[2*COORD_W-1:COORD_W];
            end
         end
         default: rsp_in.status = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (cmd.rsp_take) begin
         // held result taken by the receiver
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

### hw/rtl/costmap_obstacle_inflation_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// costmap_obstacle_inflation_core
// Obstacle inflation over a grid of Q8.8 cell costs.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction: write base cell, run inflation, read cell
//   or read centre entry. rsp_* returns exactly one result per transaction.
//   csr_* writes grid_width, grid_height, radius_sq_limit, missing_level.
// Sequence:
//   Cell write, cell read and centre read: accepted in ST_IDLE, result loaded
//   in ST_ACCESS into the result register; one transaction at a time.
//   Run: copies base to working grid (ST_COPY_RD and ST_COPY_WR per cell),
//   steps the window reach in ST_REACH, visits every grid cell (ST_CELL_RD,
//   ST_CELL_CHK), plus ST_NB_RD, and ST_NB_WR where in range, per window
//   position (2*reach+1)^2 of every obstacle; req_stall stays high throughout.
// Reset:
//   A clear pass over all CELLS cells (4096 by default) zeroes the grids and marks;
//   req_stall is high during it.
// Backpressure:
//   While rsp_stall holds a result, the next transaction is accepted only in
//   the cycle the held result is taken.
// ---------------------------------------------------------------------------
module costmap_obstacle_inflation_core
   import coi_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   parameter int MAX_REACH  = 8
)(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_data,
   input  wire logic              csr_we,
   input  wire csr_index_type     csr_index,
   input  wire logic [CSR_W-1:0]  csr_wdata
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   coi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   coi_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_REACH  (MAX_REACH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

   assign rsp_valid = sts.rsp_valid;

   // A transaction enters only while the result register is empty or frees up
   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (!rsp_valid || !rsp_stall))
      else $error("transaction accepted while result register held");

   // Every accepted transaction is followed by a busy cycle
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("back to back accept");

   // Host accesses answer once ST_ACCESS has loaded the result register
   a_access_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.op != OP_RUN) |=> ##1 rsp_valid)
      else $error("host access result missing");

   // A held result blocks new transactions
   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input open while result stalled");

endmodule
`default_nettype wire

### tb/coi_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// coi_checker
// Watches the request, result and register ports of the inflation core,
// keeps its own copy of the grids, marks and centre list, predicts one
// result per accepted transaction and compares it field by field.
// ---------------------------------------------------------------------------
module coi_checker
   import coi_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  req_type                req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  rsp_type                rsp_data,
   input  wire logic              csr_we,
   input  csr_index_type          csr_index,
   input  wire logic [CSR_W-1:0]  csr_wdata,
   output int                     fail_count
);

   localparam int GRID_DIM = 64;
   localparam int CELLS    = GRID_DIM * GRID_DIM;
   localparam int REACH_MAX = 8;

   // Shadow state
   logic signed [COST_W-1:0]  base_cost [CELLS];
   logic signed [COST_W-1:0]  work_cost [CELLS];
   bit                        marked    [CELLS];
   logic [COORD_W-1:0]        centre_c  [CELLS];
   logic [COORD_W-1:0]        centre_r  [CELLS];
   int                        centre_total;

   logic [CFG_W-1:0]          width_reg;
   logic [CFG_W-1:0]          height_reg;
   logic [CFG_W-1:0]          radius_reg;
   logic signed [COST_W-1:0]  missing_reg;

   rsp_type                   expected_rsp [$];

   initial begin
      fail_count = 0;
      centre_total = 0;
      width_reg = GRID_WIDTH_RST;
      height_reg = GRID_HEIGHT_RST;
      radius_reg = RADIUS_SQ_RST;
      missing_reg = MISSING_RST;
      for (int i = 0; i < CELLS; i++) begin
         base_cost[i] = '0;
         work_cost[i] = '0;
         marked[i] = 0;
         centre_c[i] = '0;
         centre_r[i] = '0;
      end
   end

   task automatic report(string what, int got, int want);
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   function automatic int used_width();
      return (width_reg > GRID_DIM) ? GRID_DIM : int'(width_reg);
   endfunction

   function automatic int used_height();
      return (height_reg > GRID_DIM) ? GRID_DIM : int'(height_reg);
   endfunction

   // Copy, clear, then raise free neighbors inside the disk of every obstacle
   function automatic void inflate_grid();
      int w, h, reach, lim, ny, nx, n;
      logic signed [COST_W-1:0] bv;
      w = used_width();
      h = used_height();
      lim = int'(radius_reg);
      reach = 0;
      for (int i = 0; i < CELLS; i++) begin
         work_cost[i] = base_cost[i];
         marked[i] = 0;
      end
      centre_total = 0;
      if (w == 0 || h == 0 || lim == 0)
         return;
      while (reach < REACH_MAX && (reach + 1) * (reach + 1) <= lim)
         reach++;
      for (int r = 0; r < h; r++) begin
         for (int c = 0; c < w; c++) begin
            if (base_cost[r * GRID_DIM + c] < ONE_Q88)
               continue;
            for (int dy = -reach; dy <= reach; dy++) begin
               ny = r + dy;
               if (ny < 0 || ny >= h)
                  continue;
               for (int dx = -reach; dx <= reach; dx++) begin
                  nx = c + dx;
                  if (nx < 0 || nx >= w || dx * dx + dy * dy > lim)
                     continue;
                  n = ny * GRID_DIM + nx;
                  bv = base_cost[n];
                  if (bv >= ONE_Q88 || bv <= missing_reg)
                     continue;
                  work_cost[n] = ONE_Q88;
                  if (!marked[n]) begin
                     marked[n] = 1;
                     if (centre_total < CELLS) begin
                        centre_c[centre_total] = COORD_W'(nx);
                        centre_r[centre_total] = COORD_W'(ny);
                        centre_total++;
                     end
                  end
               end
            end
         end
      end
   endfunction

   // Expected result of one transaction; updates the shadow state
   function automatic rsp_type predict_result(req_type t);
      rsp_type res;
      bit in_grid;
      int idx;
      logic signed [COST_W-1:0] v;
      res = '0;
      in_grid = (int'(t.col) < used_width()) && (int'(t.row) < used_height());
      idx = int'(t.row) * GRID_DIM + int'(t.col);
      case (t.op)
         OP_WRITE: begin
            if (in_grid) base_cost[idx] = t.cost_in;
            else res.status = 1'b1;
         end
         OP_RUN: inflate_grid();
         OP_READ: begin
            if (in_grid) begin
               v = work_cost[idx];
               res.cost_out = v;
               res.inflated = marked[idx];
               res.traversable = (v > missing_reg) && (v < ONE_Q88);
            end else begin
               res.status = 1'b1;
            end
         end
         default: begin
            if (int'(t.entry) < centre_total) begin
               res.centre_col = centre_c[t.entry];
               res.centre_row = centre_r[t.entry];
            end else begin
               res.status = 1'b1;
            end
         end
      endcase
      res.centre_count = COUNT_W'(centre_total);
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         // Register writes
         if (csr_we) begin
            case (csr_index)
               CSR_GRID_WIDTH:  width_reg <= csr_wdata[CFG_W-1:0];
               CSR_GRID_HEIGHT: height_reg <= csr_wdata[CFG_W-1:0];
               CSR_RADIUS_SQ:   radius_reg <= csr_wdata[CFG_W-1:0];
               CSR_MISSING:     missing_reg <= csr_wdata;
               default: ;
            endcase
         end
         // Result transaction
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               report("unexpected result", 1, 0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.cost_out !== want.cost_out)
                  report("cost_out", rsp_data.cost_out, want.cost_out);
               if (rsp_data.inflated !== want.inflated)
                  report("inflated", rsp_data.inflated, want.inflated);
               if (rsp_data.traversable !== want.traversable)
                  report("traversable", rsp_data.traversable, want.traversable);
               if (rsp_data.centre_col !== want.centre_col)
                  report("centre_col", rsp_data.centre_col, want.centre_col);
               if (rsp_data.centre_row !== want.centre_row)
                  report("centre_row", rsp_data.centre_row, want.centre_row);
               if (rsp_data.centre_count !== want.centre_count)
                  report("centre_count", rsp_data.centre_count, want.centre_count);
               if (rsp_data.status !== want.status)
                  report("status", rsp_data.status, want.status);
            end
         end
         // Request transaction
         if (req_valid && !req_stall)
            expected_rsp.push_back(predict_result(req_data));
      end
   end

endmodule

### tb/costmap_obstacle_inflation_core_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// costmap_obstacle_inflation_core_test
// Drives cell writes, inflation runs, cell reads and centre reads through
// the core under several grid, radius and missing-level settings, with
// random gaps and result stalls; the checker predicts and compares.
// ---------------------------------------------------------------------------
module costmap_obstacle_inflation_core_test;
   import coi_pkg::*;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp_data;
   logic              csr_we;
   csr_index_type     csr_index;
   logic [CSR_W-1:0]  csr_wdata;
   int                fail_count;

   int                sent_count;
   int                taken_count;
   bit                long_hold_done;
   int                cur_w;
   int                cur_h;
   int                cur_miss;

   costmap_obstacle_inflation_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   coi_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Results taken
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         taken_count <= taken_count + 1;
   end

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 60) return 0;
      if (sel < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // Receiver stalls; once a long hold to back the core up
   initial begin
      rsp_stall = 1'b0;
      long_hold_done = 0;
      wait (!reset);
      forever begin
         if (!long_hold_done && sent_count >= 400) begin
            long_hold_done = 1;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(20, 80)) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
            repeat (pick_gap() + 1) @(posedge clock);
         end
      end
   end

   // Offer one transaction and hold it until accepted
   task automatic send(req_type t);
      int g;
      req_valid <= 1'b1;
      req_data <= t;
      sent_count++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      g = pick_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // Drop valid and wait for every outstanding result
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (taken_count != sent_count) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, int val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(int w, int h, int rsq, int miss);
      settle();
      csr_write(CSR_GRID_WIDTH, w);
      csr_write(CSR_GRID_HEIGHT, h);
      csr_write(CSR_RADIUS_SQ, rsq);
      csr_write(CSR_MISSING, miss);
      cur_w = (w > 64) ? 64 : w;
      cur_h = (h > 64) ? 64 : h;
      cur_miss = miss;
   endtask

   function automatic req_type make_req(op_type op);
      req_type t;
      int sel, lo;
      t.op = op;
      t.col = COORD_W'($urandom);
      t.row = COORD_W'($urandom);
      t.cost_in = COST_W'($urandom);
      t.entry = ENTRY_W'($urandom);
      if (cur_w > 0 && $urandom_range(0, 9) < 8) t.col = COORD_W'($urandom_range(0, cur_w - 1));
      if (cur_h > 0 && $urandom_range(0, 9) < 8) t.row = COORD_W'($urandom_range(0, cur_h - 1));
      sel = $urandom_range(0, 9);
      lo = cur_miss + 1;
      if (sel < 2) t.cost_in = COST_W'($urandom_range(256, 32767));
      else if (sel == 2) t.cost_in = ONE_Q88;
      else if (sel < 6 && lo <= 255) t.cost_in = COST_W'(lo + $urandom_range(0, 255 - lo));
      else if (sel == 6) t.cost_in = COST_W'(-32768 + $urandom_range(0, cur_miss + 32768));
      else if (sel == 7) t.cost_in = COST_W'(255);
      if (op == OP_ENTRY && $urandom_range(0, 4) > 0) t.entry = ENTRY_W'($urandom_range(0, 40));
      return t;
   endfunction

   function automatic req_type cell_req(op_type op, int c, int r, int cost, int ent);
      req_type t;
      t.op = op;
      t.col = COORD_W'(c);
      t.row = COORD_W'(r);
      t.cost_in = COST_W'(cost);
      t.entry = ENTRY_W'(ent);
      return t;
   endfunction

   // Writes, a run, reads and centre reads, another run, more reads
   task automatic phase(int w, int h, int rsq, int miss, int items);
      int sel;
      configure(w, h, rsq, miss);
      for (int k = 0; k < items; k++) begin
         sel = $urandom_range(0, 9);
         if (k == items * 35 / 100 || k == items * 70 / 100)
            send(make_req(OP_RUN));
         else if (k < items * 35 / 100)
            send(make_req(sel < 9 ? OP_WRITE : OP_READ));
         else if (sel < 6)
            send(make_req(OP_READ));
         else if (sel < 9)
            send(make_req(OP_ENTRY));
         else
            send(make_req(OP_WRITE));
      end
   endtask

   // Stimulus and verdict
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_GRID_WIDTH;
      csr_wdata = '0;
      sent_count = 0;
      taken_count = 0;
      cur_w = 64;
      cur_h = 64;
      cur_miss = -256;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset defaults, extremes, zero radius
      send(cell_req(OP_READ, 0, 0, 0, 0));
      send(cell_req(OP_ENTRY, 0, 0, 0, 0));
      send(cell_req(OP_WRITE, 0, 0, -32768, 0));
      send(cell_req(OP_WRITE, 63, 63, 32767, 4095));
      send(cell_req(OP_WRITE, 1, 0, 256, 0));
      send(cell_req(OP_WRITE, 2, 0, 255, 0));
      send(cell_req(OP_WRITE, 3, 0, -256, 0));
      send(cell_req(OP_RUN, 0, 0, 0, 0));
      send(cell_req(OP_READ, 2, 0, 0, 0));
      send(cell_req(OP_READ, 63, 63, 0, 0));
      send(cell_req(OP_ENTRY, 0, 0, 0, 4095));
      // Empty grid: copies only, everything outside
      configure(0, 64, 9, -256);
      send(cell_req(OP_RUN, 0, 0, 0, 0));
      send(cell_req(OP_READ, 0, 0, 0, 0));
      send(cell_req(OP_WRITE, 5, 5, 256, 0));
      // Small grid with a disk, outside coordinates on both axes
      configure(4, 3, 2, -256);
      send(cell_req(OP_WRITE, 1, 1, 256, 0));
      send(cell_req(OP_WRITE, 2, 1, -256, 0));
      send(cell_req(OP_WRITE, 4, 0, 0, 0));
      send(cell_req(OP_RUN, 0, 0, 0, 0));
      send(cell_req(OP_READ, 1, 0, 0, 0));
      send(cell_req(OP_READ, 2, 1, 0, 0));
      send(cell_req(OP_READ, 0, 3, 0, 0));
      send(cell_req(OP_ENTRY, 0, 0, 0, 0));
      send(cell_req(OP_ENTRY, 0, 0, 0, 63));

      // Setting sweep, extremes among them
      phase(8, 8, 2, -256, 100);
      phase(64, 64, 64, 0, 100);
      phase(127, 127, 127, -32768, 100);
      phase(10, 10, 1, 32767, 100);
      phase(1, 1, 3, -1, 80);
      phase(64, 1, 16, -256, 80);
      phase(3, 40, 25, -100, 80);
      for (int p = 0; p < 6; p++)
         phase($urandom_range(1, 20), $urandom_range(1, 20), $urandom_range(0, 70),
               $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) - 32768
                                          : -$urandom_range(1, 512),
               95);

      settle();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("[costmap_obstacle_inflation_core] OK");
      end else begin
         $display("[costmap_obstacle_inflation_core] ERROR");
      end
      $finish;
   end

   // Run limit
   initial begin
      #400000000;
      $display("[costmap_obstacle_inflation_core] ERROR");
      $finish;
   end

endmodule
